### src/swerc_pkg.sv
// ----------------------------------------------------------------------------
// swerc_pkg
// Shared constants for the sliding window event rate checker.
// ----------------------------------------------------------------------------
package swerc_pkg;

  // Default sizes
  localparam int unsigned RingDepthDefault = 64;
  localparam int unsigned TimeWidthDefault = 32;

  // Field widths fixed by the register map
  localparam int unsigned LimitW   = 6;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegEventLimit  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWindowTicks = 1'd1;

  // Reset values
  localparam logic [LimitW-1:0]   EventLimitReset  = 6'd3;
  localparam logic [CfgDataW-1:0] WindowTicksReset = 32'd1000;

endpackage

### src/swerc_ram.sv
// ----------------------------------------------------------------------------
// swerc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module swerc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sliding_window_event_rate_checker.sv
// ----------------------------------------------------------------------------
// sliding_window_event_rate_checker
// Counts event timestamps inside a sliding window and flags a rate above limit.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                Payload
//  -------  ---  -----------------------  --------------------------------------
//  in       in   in_valid_i / in_ready_o  event_time_i
//  out      out  out_valid_o/ out_ready_i too_often_o, events_in_window_o,
//                                         store_overflow_o
//  cfg      in   cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
//  A request moves from idle to read, then to push. Unless the ring is empty or
//  the window reaches past time zero, stored times are read oldest first and each
//  one before the boundary is discarded, until one is kept or the ring empties.
//  Each stored time checked costs one RAM read plus one compare.
//  Reset clears the pointer, count, sequencer and output valid; the ring RAM is
//  not cleared since only entries inside the count are ever read.
//  A stalled output holds its result; the block waits in its push step until
//  the output register is free, and takes no request meanwhile.
//
module sliding_window_event_rate_checker
  import swerc_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDefault,
  parameter int unsigned TIME_WIDTH = TimeWidthDefault,
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  // event requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_WIDTH-1:0] event_time_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  too_often_o,
  output logic [CntW-1:0]       events_in_window_o,
  output logic                  store_overflow_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,  // waiting for a request
    StRead = 4'b0010,  // issue read of the oldest slot, or go push
    StCmp  = 4'b0100,  // compare oldest time with the boundary
    StPush = 4'b1000   // make room if full, store time, post result
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [LimitW-1:0]     limit_q;
  logic [TIME_WIDTH-1:0] window_q;

  // ring bookkeeping
  logic [PtrW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0] count_q, count_d;

  // per-request working registers
  logic [TIME_WIDTH-1:0] time_q;
  logic [TIME_WIDTH-1:0] bound_q;
  logic                  bound_ok_q;   // boundary is non-negative

  // output register
  logic            out_valid_q, out_valid_d;
  logic            too_often_q;
  logic [CntW-1:0] out_count_q;
  logic            ovf_q;

  // RAM interface
  logic                  ram_we;
  logic [PtrW-1:0]       ram_waddr;
  logic                  ram_re;
  logic [TIME_WIDTH-1:0] ram_rdata;

  // push step helpers
  logic            ring_full;
  logic [PtrW-1:0] oldest_next;
  logic [PtrW-1:0] push_oldest;
  logic [CntW-1:0] push_count;
  logic [CntW-1:0] new_count;
  logic [PtrW:0]   slot_sum;
  logic            out_free;
  logic            in_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // wrap-around increment of the oldest pointer
  assign oldest_next = (oldest_q == PtrW'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  assign ring_full   = (count_q == CntW'(RING_DEPTH));
  assign push_oldest = ring_full ? oldest_next : oldest_q;
  assign push_count  = ring_full ? CntW'(RING_DEPTH - 1) : count_q;
  assign new_count   = push_count + 1'b1;

  // newest slot = oldest + count, folded once (count < depth here)
  assign slot_sum  = {1'b0, push_oldest} + (PtrW + 1)'(push_count);
  assign ram_waddr = (slot_sum >= (PtrW + 1)'(RING_DEPTH))
                   ? PtrW'(slot_sum - (PtrW + 1)'(RING_DEPTH))
                   : slot_sum[PtrW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StRead;
        end
      end
      StRead: begin
        if (bound_ok_q && (count_q != '0)) begin
          ram_re  = 1'b1;
          state_d = StCmp;
        end else begin
          state_d = StPush;
        end
      end
      StCmp: begin
        // pop while the oldest time lies before the boundary
        if (ram_rdata < bound_q) begin
          oldest_d = oldest_next;
          count_d  = count_q - 1'b1;
          state_d  = StRead;
        end else begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (out_free) begin
          ram_we      = 1'b1;
          oldest_d    = push_oldest;
          count_d     = new_count;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      oldest_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= EventLimitReset;
      window_q    <= TIME_WIDTH'(WindowTicksReset);
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegEventLimit:  limit_q  <= cfg_data_i[LimitW-1:0];
          RegWindowTicks: window_q <= TIME_WIDTH'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // request capture: boundary t - w computed once per request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      time_q     <= event_time_i;
      bound_q    <= event_time_i - window_q;
      bound_ok_q <= (event_time_i >= window_q);
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (state_q == StPush && out_free) begin
      too_often_q <= (CmpW'(new_count) > CmpW'(limit_q));
      out_count_q <= new_count;
      ovf_q       <= ring_full;
    end
  end

  swerc_ram #(
    .Width (TIME_WIDTH),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (time_q),
    .re_i    (ram_re),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o         = (state_q == StIdle);
  assign out_valid_o        = out_valid_q;
  assign too_often_o        = too_often_q;
  assign events_in_window_o = out_count_q;
  assign store_overflow_o   = ovf_q;

endmodule
